// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define IRFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define IRFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/irfr_pkg.sv =====
// ----------------------------------------------------------------------------
// irfr_pkg
// Types, register indexes, phase codes and reset values of the IR frame
// receiver.
// ----------------------------------------------------------------------------
package irfr_pkg;

    localparam int unsigned TickW = 8;
    localparam int unsigned PosW  = 4;
    localparam int unsigned AddrW = 5;
    localparam int unsigned CmdW  = 6;

    // Configuration register indexes
    localparam logic [1:0] REG_GLITCH_TICKS = 2'd0;
    localparam logic [1:0] REG_START_TICKS  = 2'd1;
    localparam logic [1:0] REG_TOGGLE_TICKS = 2'd2;
    localparam logic [1:0] REG_BIT_TICKS    = 2'd3;

    // Reset values of the delay registers
    localparam logic [TickW-1:0] GLITCH_TICKS_RST = 8'd13;
    localparam logic [TickW-1:0] START_TICKS_RST  = 8'd51;
    localparam logic [TickW-1:0] TOGGLE_TICKS_RST = 8'd28;
    localparam logic [TickW-1:0] BIT_TICKS_RST    = 8'd55;

    // Receiver phases
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_GLITCH = 2'd1;
    localparam logic [1:0] PH_START  = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    // Bit positions within the data phase
    localparam logic [PosW-1:0] POS_TOGGLE    = 4'd1;
    localparam logic [PosW-1:0] POS_ADDR_LAST = 4'd6;
    localparam logic [PosW-1:0] POS_CMD_LAST  = 4'd12;

    typedef struct packed {
        logic             toggle_bit;
        logic [AddrW-1:0] device_address;
        logic [CmdW-1:0]  command_code;
    } t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frame_push;

endpackage

// ===== rtl/core/irfr_decoder.sv =====
// ----------------------------------------------------------------------------
// irfr_decoder
// Delay registers and frame state; one pin sample per transaction updates the
// state in a single pass and may push one decoded frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irfr_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_pin_level,
    output irfr_pkg::t_frame_push o_push
);

    logic [irfr_pkg::TickW-1:0] r_glitch_ticks, r_start_ticks;
    logic [irfr_pkg::TickW-1:0] r_toggle_ticks, r_bit_ticks;

    logic [1:0]                 r_phase, n_phase;
    logic [irfr_pkg::TickW-1:0] r_count, n_count;
    logic [irfr_pkg::PosW-1:0]  r_pos, n_pos;
    logic                       r_prev, n_prev;
    logic                       r_toggle, n_toggle;
    logic [irfr_pkg::AddrW-1:0] r_addr, n_addr;
    logic [irfr_pkg::CmdW-1:0]  r_cmd, n_cmd;

    logic [irfr_pkg::TickW-1:0] count_dec;
    logic                       push;

    // Write delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_ticks <= irfr_pkg::GLITCH_TICKS_RST;
            r_start_ticks  <= irfr_pkg::START_TICKS_RST;
            r_toggle_ticks <= irfr_pkg::TOGGLE_TICKS_RST;
            r_bit_ticks    <= irfr_pkg::BIT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                irfr_pkg::REG_GLITCH_TICKS: r_glitch_ticks <= i_cfg_data;
                irfr_pkg::REG_START_TICKS:  r_start_ticks  <= i_cfg_data;
                irfr_pkg::REG_TOGGLE_TICKS: r_toggle_ticks <= i_cfg_data;
                irfr_pkg::REG_BIT_TICKS:    r_bit_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign count_dec = r_count - 1'b1;

    // Advance the frame state for one pin sample
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_pos    = r_pos;
        n_prev   = r_prev;
        n_toggle = r_toggle;
        n_addr   = r_addr;
        n_cmd    = r_cmd;
        push     = 1'b0;
        if (i_accept) begin
            n_prev = i_pin_level;
            if (r_phase == irfr_pkg::PH_WAIT) begin
                if (r_prev && !i_pin_level) begin
                    n_phase  = irfr_pkg::PH_GLITCH;
                    n_count  = r_glitch_ticks;
                    n_toggle = 1'b0;
                    n_addr   = '0;
                    n_cmd    = '0;
                end
            end else begin
                n_count = count_dec;
                if (count_dec == '0) begin
                    case (r_phase)
                        irfr_pkg::PH_GLITCH: begin
                            if (i_pin_level) begin
                                n_phase = irfr_pkg::PH_WAIT;
                            end else begin
                                n_phase = irfr_pkg::PH_START;
                                n_count = r_start_ticks;
                            end
                        end
                        irfr_pkg::PH_START: begin
                            if (i_pin_level) begin
                                n_phase = irfr_pkg::PH_WAIT;
                            end else begin
                                n_phase  = irfr_pkg::PH_DATA;
                                n_pos    = irfr_pkg::POS_TOGGLE;
                                n_count  = r_toggle_ticks;
                                n_toggle = 1'b0;
                                n_addr   = '0;
                                n_cmd    = '0;
                            end
                        end
                        default: begin
                            if (r_pos == irfr_pkg::POS_TOGGLE) begin
                                n_toggle = i_pin_level;
                                n_pos    = r_pos + 1'b1;
                                n_count  = r_bit_ticks;
                            end else if (r_pos > irfr_pkg::POS_TOGGLE &&
                                         r_pos <= irfr_pkg::POS_ADDR_LAST) begin
                                n_addr  = {r_addr[irfr_pkg::AddrW-2:0], i_pin_level};
                                n_pos   = r_pos + 1'b1;
                                n_count = r_bit_ticks;
                            end else if (r_pos > irfr_pkg::POS_ADDR_LAST &&
                                         r_pos <= irfr_pkg::POS_CMD_LAST) begin
                                n_cmd   = {r_cmd[irfr_pkg::CmdW-2:0], i_pin_level};
                                n_pos   = r_pos + 1'b1;
                                n_count = r_bit_ticks;
                            end else begin
                                // End of frame: emit the shadows as they stand
                                push    = 1'b1;
                                n_phase = irfr_pkg::PH_WAIT;
                                n_pos   = '0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Hold the frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= irfr_pkg::PH_WAIT;
            r_count  <= '0;
            r_pos    <= '0;
            r_prev   <= 1'b1;
            r_toggle <= 1'b0;
            r_addr   <= '0;
            r_cmd    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_prev   <= n_prev;
            r_toggle <= n_toggle;
            r_addr   <= n_addr;
            r_cmd    <= n_cmd;
        end
    end

    assign o_push.valid                = push;
    assign o_push.frame.toggle_bit     = r_toggle;
    assign o_push.frame.device_address = r_addr;
    assign o_push.frame.command_code   = r_cmd;

    // Data phase always carries a live bit position
    `IRFR_ASSERT_IMP(a_data_pos, i_clk, i_rst_n, r_phase == irfr_pkg::PH_DATA,
        r_pos != '0 && r_pos <= irfr_pkg::POS_CMD_LAST + 1'b1)
    // A frame is pushed only out of the data phase, and returns to waiting
    `IRFR_ASSERT_NXT(a_push_wait, i_clk, i_rst_n, push,
        r_phase == irfr_pkg::PH_WAIT && r_pos == '0)

endmodule

// ===== rtl/core/irfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// irfr_out_buf
// Result register with a skid stage, so that pin samples keep flowing while
// a decoded frame waits at the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irfr_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irfr_pkg::t_frame_push i_push,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output irfr_pkg::t_frame      o_frame
);

    logic             r_out_valid, r_skid_valid;
    irfr_pkg::t_frame r_out, r_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_frame = r_out;

    // Move frames through the output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push.valid;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= i_push.valid;
        end else if (i_push.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push.valid) begin
                r_out <= i_push.frame;
            end
        end else if (!r_out_valid) begin
            if (i_push.valid) begin
                r_out <= i_push.frame;
            end
        end else if (i_push.valid) begin
            r_skid <= i_push.frame;
        end
    end

    // Skid holds a frame only behind a pending output frame
    `IRFR_ASSERT_IMP(a_skid_behind, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // No frame arrives while the skid stage is full
    `IRFR_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_skid_valid, !i_push.valid)

endmodule

// ===== rtl/core/ir_remote_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ir_remote_frame_receiver
// RC5-style infrared frame receiver: one receiver pin sample per transaction,
// one frame (toggle, address, command) per completed reception.
//
//   Channel  Direction  Handshake                    Payload
//   sample   in         i_in_valid / o_in_ready      i_pin_level
//   frame    out        o_out_valid / i_out_ready    o_toggle_bit, o_device_address,
//                                                    o_command_code
//   config   in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One sample is taken every cycle while o_in_ready is high; the state update is a
// single pass between the frame state registers and the result register.
// A finished frame is registered in the result register, or in the skid register.
// Reset is synchronous, active low; delay registers return to 13/51/28/55.
// o_in_ready drops only while both the result and skid registers hold frames.
// ----------------------------------------------------------------------------
module ir_remote_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_pin_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_toggle_bit,
    output logic [4:0] o_device_address,
    output logic [5:0] o_command_code
);

    irfr_pkg::t_frame_push push;
    irfr_pkg::t_frame      frame;
    logic                  accept;

    assign accept = i_in_valid && o_in_ready;

    irfr_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .o_push      (push)
    );

    irfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_frame (frame)
    );

    assign o_toggle_bit     = frame.toggle_bit;
    assign o_device_address = frame.device_address;
    assign o_command_code   = frame.command_code;

endmodule

// ===== sim/tb_ir_remote_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_remote_frame_receiver
// Drives pin samples into the IR frame receiver and checks every frame it
// emits. A mirror of the receiver state machine runs on each accepted sample
// and queues the frame it expects. The stimulus is mostly well-formed frames
// built from the mirrored state, with bursts of noise, glitches and failed
// start bits. The delay registers are swept through small values, reset
// values and both extremes, some of them loaded while a delay is running.
// ----------------------------------------------------------------------------

class rc5_frame_tracker;

    logic [irfr_pkg::TickW-1:0] delay_reg [4];
    logic [1:0]                 phase;
    logic [irfr_pkg::TickW-1:0] countdown;
    logic [irfr_pkg::PosW-1:0]  bit_pos;
    logic                       prev_level;
    irfr_pkg::t_frame           shadow;
    irfr_pkg::t_frame           pending_frames [$];
    int unsigned                errors;

    function new();
        delay_reg[irfr_pkg::REG_GLITCH_TICKS] = irfr_pkg::GLITCH_TICKS_RST;
        delay_reg[irfr_pkg::REG_START_TICKS]  = irfr_pkg::START_TICKS_RST;
        delay_reg[irfr_pkg::REG_TOGGLE_TICKS] = irfr_pkg::TOGGLE_TICKS_RST;
        delay_reg[irfr_pkg::REG_BIT_TICKS]    = irfr_pkg::BIT_TICKS_RST;
        phase      = irfr_pkg::PH_WAIT;
        countdown  = '0;
        bit_pos    = '0;
        prev_level = 1'b1;
        shadow     = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [irfr_pkg::TickW-1:0] val);
        delay_reg[idx] = val;
    endfunction

    // Advance the receiver by one pin sample; queue the frame when one completes
    function void take_sample(logic pin);
        if (phase == irfr_pkg::PH_WAIT) begin
            if (prev_level && !pin) begin
                phase     = irfr_pkg::PH_GLITCH;
                countdown = delay_reg[irfr_pkg::REG_GLITCH_TICKS];
                shadow    = '0;
            end
        end else begin
            countdown = countdown - 1'b1;
            if (countdown == '0) begin
                case (phase)
                    irfr_pkg::PH_GLITCH: begin
                        if (pin) begin
                            phase = irfr_pkg::PH_WAIT;
                        end else begin
                            phase     = irfr_pkg::PH_START;
                            countdown = delay_reg[irfr_pkg::REG_START_TICKS];
                        end
                    end
                    irfr_pkg::PH_START: begin
                        if (pin) begin
                            phase = irfr_pkg::PH_WAIT;
                        end else begin
                            shadow    = '0;
                            phase     = irfr_pkg::PH_DATA;
                            bit_pos   = irfr_pkg::POS_TOGGLE;
                            countdown = delay_reg[irfr_pkg::REG_TOGGLE_TICKS];
                        end
                    end
                    default: begin
                        if (bit_pos == irfr_pkg::POS_TOGGLE) begin
                            shadow.toggle_bit = pin;
                            bit_pos   = bit_pos + 1'b1;
                            countdown = delay_reg[irfr_pkg::REG_BIT_TICKS];
                        end else if (bit_pos > irfr_pkg::POS_TOGGLE &&
                                     bit_pos <= irfr_pkg::POS_ADDR_LAST) begin
                            shadow.device_address =
                                {shadow.device_address[irfr_pkg::AddrW-2:0], pin};
                            bit_pos   = bit_pos + 1'b1;
                            countdown = delay_reg[irfr_pkg::REG_BIT_TICKS];
                        end else if (bit_pos > irfr_pkg::POS_ADDR_LAST &&
                                     bit_pos <= irfr_pkg::POS_CMD_LAST) begin
                            shadow.command_code =
                                {shadow.command_code[irfr_pkg::CmdW-2:0], pin};
                            bit_pos   = bit_pos + 1'b1;
                            countdown = delay_reg[irfr_pkg::REG_BIT_TICKS];
                        end else begin
                            // Past the last command bit: the frame is complete
                            pending_frames.push_back(shadow);
                            phase   = irfr_pkg::PH_WAIT;
                            bit_pos = '0;
                        end
                    end
                endcase
            end
        end
        prev_level = pin;
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare an emitted frame with the oldest one expected
    function void match_frame(irfr_pkg::t_frame got);
        irfr_pkg::t_frame want;
        if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_frames.pop_front();
        check_field("toggle_bit", want.toggle_bit, got.toggle_bit);
        check_field("device_address", want.device_address, got.device_address);
        check_field("command_code", want.command_code, got.command_code);
    endfunction

endclass

module tb_ir_remote_frame_receiver;

    localparam int RANDOM_SMALL    = -1;
    localparam int NUM_SETS        = 9;
    localparam int LAST_SET_A      = 2;
    localparam int LAST_SET_B      = 6;
    localparam int PRESSURE_SET    = 8;
    localparam int HOLD_OFF_CYCLES = 150;

    localparam logic [1:0] REG_ORDER [4] = '{irfr_pkg::REG_GLITCH_TICKS,
                                            irfr_pkg::REG_START_TICKS,
                                            irfr_pkg::REG_TOGGLE_TICKS,
                                            irfr_pkg::REG_BIT_TICKS};

    // Delay register values and sample count of each stimulus set
    localparam int DELAY_SETS [NUM_SETS][4] = '{
        '{1, 1, 1, 1},
        '{RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL},
        '{13, 51, 28, 55},
        '{RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL},
        '{255, 1, 1, 1},
        '{0, 255, 0, 0},
        '{1, 1, 1, 255},
        '{RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL, RANDOM_SMALL},
        '{1, 1, 1, 1}
    };
    localparam int SET_LEN [NUM_SETS] = '{21, 380, 200, 200, 250, 250, 200, 250, 200};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = irfr_pkg::REG_GLITCH_TICKS;
    logic [7:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic       i_pin_level = 1'b1;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_toggle_bit;
    logic [4:0] o_device_address;
    logic [5:0] o_command_code;

    rc5_frame_tracker tracker = new();

    int   samples_to_offer = 0;
    int   noise_left       = 0;
    int   src_idle_pct     = 0;
    int   snk_idle_pct     = 0;
    bit   stall_request    = 1'b0;
    int   stall_cycles     = 0;
    logic directed_pins [$];

    ir_remote_frame_receiver u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pin_level      (i_pin_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_toggle_bit     (o_toggle_bit),
        .o_device_address (o_device_address),
        .o_command_code   (o_command_code)
    );

    always #10 i_clk = ~i_clk;

    // Choose the next pin level from the mirrored receiver state
    function automatic logic pick_pin();
        logic pin;
        if (directed_pins.size() > 0) begin
            return directed_pins.pop_front();
        end
        if (noise_left > 0) begin
            noise_left--;
            return logic'($urandom_range(1));
        end
        if ($urandom_range(99) < 3) begin
            noise_left = $urandom_range(12, 1);
        end
        case (tracker.phase)
            irfr_pkg::PH_WAIT: begin
                // Idle high for a few ticks, then a falling edge
                pin = tracker.prev_level ? ($urandom_range(3) != 0) : 1'b1;
            end
            irfr_pkg::PH_GLITCH, irfr_pkg::PH_START: begin
                // Mostly hold low at the check; occasionally fail it
                if (tracker.countdown == 1)
                    pin = ($urandom_range(99) < 8);
                else
                    pin = ($urandom_range(99) < 30);
            end
            default: begin
                pin = logic'($urandom_range(1));
            end
        endcase
        return pin;
    endfunction

    // Sample source: note accepted transactions, offer the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.take_sample(i_pin_level);
            if (!i_in_valid || o_in_ready) begin
                if (samples_to_offer > 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_pin_level <= pick_pin();
                    samples_to_offer = samples_to_offer - 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Frame sink: check accepted transactions, stall at random or on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                tracker.match_frame(irfr_pkg::t_frame'({o_toggle_bit, o_device_address,
                                                        o_command_code}));
            if (stall_cycles > 0) begin
                stall_cycles = stall_cycles - 1;
                i_out_ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                stall_cycles  = HOLD_OFF_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tracker.set_reg(idx, val);
    endtask

    // Wait until every sample is taken and every expected frame has arrived
    task automatic drain();
        do @(posedge i_clk); while (samples_to_offer != 0 || i_in_valid);
        while (tracker.pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < NUM_SETS; s++) begin
            for (int r = 0; r < 4; r++) begin
                v = (DELAY_SETS[s][r] == RANDOM_SMALL) ? $urandom_range(4, 1)
                                                       : DELAY_SETS[s][r];
                write_reg(REG_ORDER[r], v[7:0]);
            end
            @(posedge i_clk) i_cfg_we <= 1'b0;

            @(negedge i_clk);
            if (s == 0) begin
                // All-ones frame at the shortest delays, then a glitch,
                // then a start bit that fails its check
                directed_pins = '{1'b0, 1'b0, 1'b0, 1'b1,
                                  1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                  1'b1,
                                  1'b0, 1'b1,
                                  1'b0, 1'b0, 1'b1};
            end
            if (s <= LAST_SET_A) begin
                src_idle_pct = 9;
                snk_idle_pct = 75;
            end else if (s <= LAST_SET_B) begin
                src_idle_pct = 75;
                snk_idle_pct = 9;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (s == PRESSURE_SET)
                stall_request = 1'b1;
            samples_to_offer = SET_LEN[s];
            drain();
        end

        if (tracker.errors == 0 && tracker.pending_frames.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/irfr_pkg.sv
rtl/core/irfr_decoder.sv
rtl/core/irfr_out_buf.sv
rtl/core/ir_remote_frame_receiver.sv
sim/tb_ir_remote_frame_receiver.sv
